@@ hw/rtl/single_wire_sensor_frame_decoder_core_defines.svh @@
// Assertion macros shared by the single-wire sensor frame decoder RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWSFD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swsfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWSFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swsfd assertion failed");

`endif

@@ hw/rtl/swsfd_pkg.sv @@
// Package for the single-wire sensor frame decoder: widths, codes, reset values and types.
// No dependencies; used by the interfaces and all modules.
package swsfd_pkg;

    localparam int TIMESTAMP_WIDTH_DEFAULT = 32;
    localparam int TIME_IN_W   = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int HUM_W       = 12;
    localparam int TEMP_W      = 11;
    localparam int PACKED_W    = 21;
    localparam int FRAME_W     = 40;
    localparam int COUNT_W     = 6;
    localparam int BIT_MIN_W   = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int FRAME_BITS  = 40;
    localparam int TENS_SCALE  = 10;
    localparam int PACK_SCALE  = 1000;

    localparam logic [BIT_MIN_W-1:0] BIT_ONE_MIN_RESET   = 8'd45;
    localparam logic [TIMEOUT_W-1:0] FRAME_TIMEOUT_RESET = 16'd10000;

    typedef enum logic [REQ_W-1:0] {
        REQ_ARM  = 2'd0,
        REQ_EDGE = 2'd1,
        REQ_TICK = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_NEGATIVE = 2'd3
    } status_t;

    typedef struct packed {
        logic [BIT_MIN_W-1:0] bit_one_min_us;
        logic [TIMEOUT_W-1:0] frame_timeout_us;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               timeout;
        logic [FRAME_W-1:0] frame;
    } event_t;

endpackage

@@ hw/rtl/swsfd_if.sv @@
// Request and response channel interfaces of the frame decoder.
// Depends on swsfd_pkg for field widths.
interface swsfd_req_if;
    import swsfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic                 line_level;
    logic [TIME_IN_W-1:0] time_us;

    modport source (output valid, req_type, line_level, time_us, input ready);
    modport sink (input valid, req_type, line_level, time_us, output ready);
endinterface

interface swsfd_rsp_if;
    import swsfd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HUM_W-1:0]    humidity_tenths;
    logic [TEMP_W-1:0]   temperature_tenths;
    logic [PACKED_W-1:0] packed_reading;

    modport source (output valid, status, humidity_tenths, temperature_tenths,
                    packed_reading, input ready);
    modport sink (input valid, status, humidity_tenths, temperature_tenths,
                  packed_reading, output ready);
endinterface

@@ hw/rtl/swsfd_cfg_regs.sv @@
// APB-style configuration registers: pulse threshold and frame timeout.
// Depends on swsfd_pkg.
module swsfd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swsfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swsfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swsfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output swsfd_pkg::cfg_t                  cfg
);
    import swsfd_pkg::*;

    localparam logic REG_BIT_ONE_MIN   = 1'b0;
    localparam logic REG_FRAME_TIMEOUT = 1'b1;

    logic [BIT_MIN_W-1:0] bit_one_min_reg;
    logic [TIMEOUT_W-1:0] frame_timeout_reg;
    logic                 wr_en;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_one_min_reg   <= BIT_ONE_MIN_RESET;
            frame_timeout_reg <= FRAME_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_BIT_ONE_MIN:   bit_one_min_reg   <= pwdata[BIT_MIN_W-1:0];
                REG_FRAME_TIMEOUT: frame_timeout_reg <= pwdata[TIMEOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BIT_ONE_MIN:   prdata = APB_DATA_W'(bit_one_min_reg);
            REG_FRAME_TIMEOUT: prdata = APB_DATA_W'(frame_timeout_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.bit_one_min_us   = bit_one_min_reg;
    assign cfg.frame_timeout_us = frame_timeout_reg;

endmodule

@@ hw/rtl/swsfd_frame_fsm.sv @@
// Frame state machine: tracks the response phases, measures bit pulses and
// raises a registered frame-done or timeout event. Depends on swsfd_pkg and the defines header.
module swsfd_frame_fsm #(
    parameter int TIMESTAMP_WIDTH = swsfd_pkg::TIMESTAMP_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swsfd_pkg::cfg_t   cfg,
    swsfd_req_if.sink         req,
    input  logic              ev_ready,
    output swsfd_pkg::event_t ev
);
    import swsfd_pkg::*;
    `include "single_wire_sensor_frame_decoder_core_defines.svh"

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_FIRST_LOW,
        PH_BIT_HIGH,
        PH_BIT_LOW
    } phase_t;

    localparam logic [COUNT_W-1:0] LAST_BIT = COUNT_W'(FRAME_BITS - 1);

    phase_t                     phase_reg, phase_next;
    logic [FRAME_W-1:0]         frame_bits_reg, frame_bits_next;
    logic [COUNT_W-1:0]         bit_count_reg, bit_count_next;
    logic [TIMESTAMP_WIDTH-1:0] high_start_reg, high_start_next;
    logic [TIMESTAMP_WIDTH-1:0] arm_time_reg, arm_time_next;
    event_t                     ev_reg, ev_next;

    logic [TIMESTAMP_WIDTH+TIME_IN_W-1:0] time_ext;
    logic [TIMESTAMP_WIDTH-1:0]           now;
    logic [TIMESTAMP_WIDTH-1:0]           since_arm;
    logic [TIMESTAMP_WIDTH-1:0]           pulse_width;
    logic                                 expired;
    logic                                 bit_val;
    logic                                 stage_en;
    logic                                 accept;

    assign stage_en  = !ev_reg.valid || ev_ready;
    assign req.ready = stage_en;
    assign accept    = req.valid && stage_en;
    assign ev        = ev_reg;

    assign time_ext    = {{TIMESTAMP_WIDTH{1'b0}}, req.time_us};
    assign now         = time_ext[TIMESTAMP_WIDTH-1:0];
    assign since_arm   = now - arm_time_reg;
    assign pulse_width = now - high_start_reg;
    assign expired     = since_arm >= TIMESTAMP_WIDTH'(cfg.frame_timeout_us);
    assign bit_val     = pulse_width > TIMESTAMP_WIDTH'(cfg.bit_one_min_us);

    always_comb
    begin
        phase_next      = phase_reg;
        frame_bits_next = frame_bits_reg;
        bit_count_next  = bit_count_reg;
        high_start_next = high_start_reg;
        arm_time_next   = arm_time_reg;
        ev_next         = ev_reg;

        if (stage_en)
        begin
            ev_next.valid   = 1'b0;
            ev_next.timeout = 1'b0;
        end

        if (accept)
        begin
            if (req.req_type == REQ_ARM)
            begin
                frame_bits_next = '0;
                bit_count_next  = '0;
                arm_time_next   = now;
                phase_next      = PH_RESP_LOW;
            end
            else if ((req.req_type == REQ_EDGE || req.req_type == REQ_TICK)
                     && phase_reg != PH_IDLE)
            begin
                if (expired)
                begin
                    phase_next      = PH_IDLE;
                    ev_next.valid   = 1'b1;
                    ev_next.timeout = 1'b1;
                end
                else if (req.req_type == REQ_EDGE)
                begin
                    unique case (phase_reg)
                        PH_RESP_LOW:
                        begin
                            if (!req.line_level)
                                phase_next = PH_RESP_HIGH;
                        end
                        PH_RESP_HIGH:
                        begin
                            if (req.line_level)
                                phase_next = PH_FIRST_LOW;
                        end
                        PH_FIRST_LOW:
                        begin
                            if (!req.line_level)
                                phase_next = PH_BIT_HIGH;
                        end
                        PH_BIT_HIGH:
                        begin
                            if (req.line_level)
                            begin
                                high_start_next = now;
                                phase_next      = PH_BIT_LOW;
                            end
                        end
                        PH_BIT_LOW:
                        begin
                            if (!req.line_level)
                            begin
                                frame_bits_next = {frame_bits_reg[FRAME_W-2:0], bit_val};
                                bit_count_next  = bit_count_reg + COUNT_W'(1);
                                if (bit_count_reg == LAST_BIT)
                                begin
                                    phase_next    = PH_IDLE;
                                    ev_next.valid = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_BIT_HIGH;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            ev_next.frame = frame_bits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            frame_bits_reg <= '0;
            bit_count_reg  <= '0;
            high_start_reg <= '0;
            arm_time_reg   <= '0;
            ev_reg         <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_bits_reg <= frame_bits_next;
            bit_count_reg  <= bit_count_next;
            high_start_reg <= high_start_next;
            arm_time_reg   <= arm_time_next;
            ev_reg         <= ev_next;
        end
    end

    `SWSFD_ASSERT_NEXT(a_arm_restarts, accept && req.req_type == REQ_ARM,
                       phase_reg == PH_RESP_LOW && bit_count_reg == '0)
    `SWSFD_ASSERT_NEXT(a_idle_no_event, accept && phase_reg == PH_IDLE, !ev_reg.valid)
    `SWSFD_ASSERT_NEXT(a_event_held, ev_reg.valid && !ev_ready, $stable(ev_reg))
    `SWSFD_ASSERT_IMP(a_count_range, phase_reg != PH_IDLE, bit_count_reg <= LAST_BIT)

endmodule

@@ hw/rtl/swsfd_reading_calc.sv @@
// Result pipeline: checksum and tenths decode, then packing into the output register.
// Depends on swsfd_pkg and the defines header.
module swsfd_reading_calc (
    input  logic              clk,
    input  logic              rst_n,
    input  swsfd_pkg::event_t ev,
    output logic              ev_ready,
    swsfd_rsp_if.source       rsp
);
    import swsfd_pkg::*;
    `include "single_wire_sensor_frame_decoder_core_defines.svh"

    logic [7:0] b0, b1, b2, b3, b4;
    logic [7:0] byte_sum;
    logic [HUM_W-1:0]  hum;
    logic [TEMP_W-1:0] temp;
    status_t           status;

    logic              chk_valid_reg, chk_valid_next;
    status_t           chk_status_reg, chk_status_next;
    logic [HUM_W-1:0]  chk_hum_reg, chk_hum_next;
    logic [TEMP_W-1:0] chk_temp_reg, chk_temp_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [HUM_W-1:0]    out_hum_reg, out_hum_next;
    logic [TEMP_W-1:0]   out_temp_reg, out_temp_next;
    logic [PACKED_W-1:0] out_packed_reg, out_packed_next;

    logic chk_en;
    logic out_en;

    assign out_en   = !out_valid_reg || rsp.ready;
    assign chk_en   = !chk_valid_reg || out_en;
    assign ev_ready = chk_en;

    assign b0 = ev.frame[39:32];
    assign b1 = ev.frame[31:24];
    assign b2 = ev.frame[23:16];
    assign b3 = ev.frame[15:8];
    assign b4 = ev.frame[7:0];

    always_comb
    begin
        byte_sum = b0 + b1 + b2 + b3;
        hum      = HUM_W'(b0) * HUM_W'(TENS_SCALE) + HUM_W'(b1);
        temp     = TEMP_W'(b2[6:0]) * TEMP_W'(TENS_SCALE) + TEMP_W'(b3);
        if (ev.timeout)
        begin
            status = ST_TIMEOUT;
            hum    = '0;
            temp   = '0;
        end
        else if (byte_sum != b4)
            status = ST_CHECKSUM;
        else if (b2[7] && temp != '0)
            status = ST_NEGATIVE;
        else
            status = ST_OK;
    end

    always_comb
    begin
        chk_valid_next  = chk_valid_reg;
        chk_status_next = chk_status_reg;
        chk_hum_next    = chk_hum_reg;
        chk_temp_next   = chk_temp_reg;
        if (chk_en)
        begin
            chk_valid_next  = ev.valid;
            chk_status_next = status;
            chk_hum_next    = hum;
            chk_temp_next   = temp;
        end

        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_hum_next    = out_hum_reg;
        out_temp_next   = out_temp_reg;
        out_packed_next = out_packed_reg;
        if (out_en)
        begin
            out_valid_next  = chk_valid_reg;
            out_status_next = chk_status_reg;
            out_hum_next    = chk_hum_reg;
            out_temp_next   = chk_temp_reg;
            if (chk_status_reg == ST_OK)
                out_packed_next = PACKED_W'(chk_temp_reg) * PACKED_W'(PACK_SCALE)
                                  + PACKED_W'(chk_hum_reg);
            else
                out_packed_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_status_reg <= chk_status_next;
        chk_hum_reg    <= chk_hum_next;
        chk_temp_reg   <= chk_temp_next;
        out_status_reg <= out_status_next;
        out_hum_reg    <= out_hum_next;
        out_temp_reg   <= out_temp_next;
        out_packed_reg <= out_packed_next;
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.humidity_tenths    = out_hum_reg;
    assign rsp.temperature_tenths = out_temp_reg;
    assign rsp.packed_reading     = out_packed_reg;

    `SWSFD_ASSERT_NEXT(a_event_taken, ev.valid && chk_en, chk_valid_reg)
    `SWSFD_ASSERT_IMP(a_error_unpacked, out_valid_reg && out_status_reg != ST_OK,
                      out_packed_reg == '0)
    `SWSFD_ASSERT_IMP(a_timeout_zero, out_valid_reg && out_status_reg == ST_TIMEOUT,
                      out_hum_reg == '0 && out_temp_reg == '0)

endmodule

@@ hw/rtl/single_wire_sensor_frame_decoder_core.sv @@
// Single-wire sensor frame decoder, top level; depends on swsfd_pkg, the interfaces and submodules.
// A completing transaction's result passes through the event, check and output registers to rsp.
// Throughput: one request transaction per cycle; requests stall only while the event, check
// and output registers all hold a result and rsp.ready is low.
// Reset (rst_n, async, active low) idles the frame state and restores register defaults.
module single_wire_sensor_frame_decoder_core #(
    parameter int TIMESTAMP_WIDTH = swsfd_pkg::TIMESTAMP_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    swsfd_req_if.sink                        req,
    swsfd_rsp_if.source                      rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swsfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swsfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swsfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import swsfd_pkg::*;

    cfg_t   cfg;
    event_t ev;
    logic   ev_ready;

    swsfd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swsfd_frame_fsm #(
        .TIMESTAMP_WIDTH (TIMESTAMP_WIDTH)
    ) u_frame_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .ev_ready (ev_ready),
        .ev       (ev)
    );

    swsfd_reading_calc u_reading_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .ev_ready (ev_ready),
        .rsp      (rsp)
    );

endmodule

@@ bench/single_wire_sensor_frame_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for single_wire_sensor_frame_decoder_core: drives arm, edge and tick
// transactions, takes each reading from a behavioral decoder or a directed row and compares it field by field.
// Depends on swsfd_pkg, the swsfd channel interfaces and the decoder RTL.
module single_wire_sensor_frame_decoder_core_tb;
    import swsfd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int REG_BIT_ONE_MIN   = 0;
    localparam int REG_FRAME_TIMEOUT = 1;
    localparam int SETTLE_CYCLES     = 12;
    localparam int RSP_HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS       = 20;
    localparam int PHASE_READINGS    = 1;
    localparam int PRESSURE_PAIRS    = 25;
    localparam longint CYCLE_LIMIT   = 1000000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_FIRST_LOW,
        PH_BIT_HIGH,
        PH_BIT_LOW
    } line_phase_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_GIVEN
    } check_mode_t;

    typedef struct packed {
        status_t             status;
        logic [HUM_W-1:0]    humidity;
        logic [TEMP_W-1:0]   temperature;
        logic [PACKED_W-1:0] combined;
    } reading_t;

    typedef struct packed {
        logic [REQ_W-1:0]     kind;
        logic                 level;
        logic [TIME_IN_W-1:0] stamp;
        check_mode_t          mode;
        reading_t             given;
    } vector_t;

    localparam reading_t TIMEOUT_READING = '{ST_TIMEOUT, 12'd0, 11'd0, 21'd0};

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    swsfd_req_if req_ch ();
    swsfd_rsp_if rsp_ch ();

    single_wire_sensor_frame_decoder_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Decoder state as the predictor sees it.
    line_phase_t          line_phase    = PH_IDLE;
    logic [FRAME_W-1:0]   frame_store   = '0;
    logic [COUNT_W-1:0]   bits_seen     = '0;
    logic [TIME_IN_W-1:0] pulse_start   = '0;
    logic [TIME_IN_W-1:0] armed_at      = '0;
    logic [BIT_MIN_W-1:0] one_threshold = BIT_ONE_MIN_RESET;
    logic [TIMEOUT_W-1:0] timeout_limit = FRAME_TIMEOUT_RESET;

    reading_t readings_due[$];
    vector_t  directed_q[$];
    check_mode_t cur_mode;
    reading_t cur_given;
    logic [TIME_IN_W-1:0] now_us;
    bit idle_on;
    int hold_count;
    int items_sent;
    int readings_predicted;
    int errors;
    longint cycle_count;

    task automatic decode_step(input logic [REQ_W-1:0] kind, input logic level,
                               input logic [TIME_IN_W-1:0] stamp,
                               output bit fires, output reading_t r);
        logic [TIME_IN_W-1:0] elapsed;
        logic [TIME_IN_W-1:0] width;
        int b0, b1, b2, b3, b4, hum, temp;
        fires = 1'b0;
        r = '0;
        if (kind == REQ_ARM) begin
            frame_store = '0;
            bits_seen = '0;
            armed_at = stamp;
            line_phase = PH_RESP_LOW;
        end else if (kind != REQ_UNUSED && line_phase != PH_IDLE) begin
            elapsed = stamp - armed_at;
            if (elapsed >= {16'd0, timeout_limit}) begin
                line_phase = PH_IDLE;
                fires = 1'b1;
                r = TIMEOUT_READING;
            end else if (kind == REQ_EDGE) begin
                case (line_phase)
                    PH_RESP_LOW:  if (!level) line_phase = PH_RESP_HIGH;
                    PH_RESP_HIGH: if (level) line_phase = PH_FIRST_LOW;
                    PH_FIRST_LOW: if (!level) line_phase = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                        if (level) begin
                            pulse_start = stamp;
                            line_phase = PH_BIT_LOW;
                        end
                    PH_BIT_LOW:
                        if (!level) begin
                            width = stamp - pulse_start;
                            frame_store = {frame_store[FRAME_W-2:0],
                                           width > {24'd0, one_threshold}};
                            bits_seen = bits_seen + 1'b1;
                            if (bits_seen >= FRAME_BITS) begin
                                line_phase = PH_IDLE;
                                fires = 1'b1;
                                b0 = int'(frame_store[39:32]);
                                b1 = int'(frame_store[31:24]);
                                b2 = int'(frame_store[23:16]);
                                b3 = int'(frame_store[15:8]);
                                b4 = int'(frame_store[7:0]);
                                hum = b0 * TENS_SCALE + b1;
                                temp = (b2 % 128) * TENS_SCALE + b3;
                                r.humidity = HUM_W'(hum);
                                r.temperature = TEMP_W'(temp);
                                r.combined = '0;
                                if (((b0 + b1 + b2 + b3) % 256) != b4) begin
                                    r.status = ST_CHECKSUM;
                                end else if (b2 >= 128 && temp != 0) begin
                                    r.status = ST_NEGATIVE;
                                end else begin
                                    r.status = ST_OK;
                                    r.combined = PACKED_W'(temp * PACK_SCALE + hum);
                                end
                            end else begin
                                line_phase = PH_BIT_HIGH;
                            end
                        end
                    default: line_phase = PH_IDLE;
                endcase
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        bit fires;
        reading_t r;
        reading_t e;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            decode_step(req_ch.req_type, req_ch.line_level, req_ch.time_us, fires, r);
            if (cur_mode == CHK_GIVEN) begin
                readings_due.push_back(cur_given);
                readings_predicted++;
            end else if (cur_mode == CHK_PREDICT && fires) begin
                readings_due.push_back(r);
                readings_predicted++;
            end
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (readings_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected reading, expected none, actual status %0d hum %0d",
                         $time, rsp_ch.status, rsp_ch.humidity_tenths);
            end else begin
                e = readings_due.pop_front();
                check_field("status", 32'(e.status), 32'(rsp_ch.status));
                check_field("humidity_tenths", 32'(e.humidity), 32'(rsp_ch.humidity_tenths));
                check_field("temperature_tenths", 32'(e.temperature),
                            32'(rsp_ch.temperature_tenths));
                check_field("packed_reading", 32'(e.combined), 32'(rsp_ch.packed_reading));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("single_wire_sensor_frame_decoder_core: mismatch");
            $finish;
        end
    end

    initial
    begin : receiver
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_count) begin
                hold_seen = hold_count;
                stall_left = RSP_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                rsp_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 3);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Called right after a rising edge; returns right after the edge that accepts the transaction.
    task automatic send(input logic [REQ_W-1:0] kind, input logic level,
                        input logic [TIME_IN_W-1:0] stamp, input check_mode_t mode,
                        input reading_t given);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.line_level <= level;
        req_ch.time_us <= stamp;
        cur_mode <= mode;
        cur_given <= given;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic put(input logic [REQ_W-1:0] kind, input logic level,
                       input logic [TIME_IN_W-1:0] stamp);
        send(kind, level, stamp, CHK_PREDICT, '0);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_read_check(input int index);
        logic [APB_DATA_W-1:0] want;
        want = (index == REG_BIT_ONE_MIN) ? {24'd0, one_threshold} : {16'd0, timeout_limit};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_ADDR_W'(index * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want) begin
            errors++;
            $display("%0t: register %0d expected %0d, actual %0d", $time, index, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input int index, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(index * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (index == REG_BIT_ONE_MIN)
            one_threshold = value[BIT_MIN_W-1:0];
        else
            timeout_limit = value[TIMEOUT_W-1:0];
        @(posedge clk);
        cfg_read_check(index);
    endtask

    // Sends arm, the three response edges and the first nbits data bits of a frame.
    task automatic send_frame(input logic [FRAME_W-1:0] frame, input int nbits, input bit noisy);
        int i;
        int width;
        put(REQ_ARM, 1'($urandom_range(0, 1)), now_us);
        now_us += $urandom_range(18, 40);
        put(REQ_EDGE, 1'b0, now_us);
        now_us += $urandom_range(60, 90);
        put(REQ_EDGE, 1'b1, now_us);
        now_us += $urandom_range(60, 90);
        put(REQ_EDGE, 1'b0, now_us);
        for (i = 0; i < nbits; i++) begin
            now_us += $urandom_range(0, 60);
            put(REQ_EDGE, 1'b1, now_us);
            if (noisy && $urandom_range(0, 19) == 0)
                put(($urandom_range(0, 1) != 0) ? REQ_TICK : REQ_EDGE, 1'b1,
                    now_us + $urandom_range(0, 5));
            if (frame[FRAME_W-1-i])
                width = one_threshold + (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 40));
            else
                width = ($urandom_range(0, 3) == 0) ? one_threshold
                                                     : $urandom_range(0, one_threshold);
            now_us += TIME_IN_W'(width);
            put(REQ_EDGE, 1'b0, now_us);
        end
    endtask

    function automatic logic [FRAME_W-1:0] make_frame();
        logic [7:0] b0, b1, b2, b3, b4;
        int pick;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            b2 = 8'h80;
            b3 = 8'h00;
        end else if (pick < 5) begin
            b2[7] = 1'b0;
        end
        b4 = b0 + b1 + b2 + b3;
        if ($urandom_range(0, 3) == 0)
            b4 = b4 ^ 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, b4};
    endfunction

    task automatic random_phase(input int item_goal, input int reading_goal);
        int items0, readings0, pick, n;
        items0 = items_sent;
        readings0 = readings_predicted;
        while (items_sent - items0 < item_goal || readings_predicted - readings0 < reading_goal)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) == 0)
                now_us = 32'hFFFF_FFFF - $urandom_range(0, 6000);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_frame(make_frame(), FRAME_BITS, 1'($urandom_range(0, 1)));
            end else if (pick < 70) begin
                send_frame(make_frame(), $urandom_range(0, FRAME_BITS - 1), 1'b1);
                if ($urandom_range(0, 1) != 0) begin
                    now_us += timeout_limit;
                    put(REQ_TICK, 1'($urandom_range(0, 1)), now_us);
                end
            end else if (pick < 85) begin
                put(REQ_ARM, 1'($urandom_range(0, 1)), now_us);
                now_us += timeout_limit - $urandom_range(0, 1);
                put(($urandom_range(0, 1) != 0) ? REQ_TICK : REQ_EDGE,
                    1'($urandom_range(0, 1)), now_us);
                now_us += 1;
                put(REQ_TICK, 1'b0, now_us);
            end else begin
                n = $urandom_range(2, 8);
                repeat (n) begin
                    now_us += $urandom_range(0, 3000);
                    put(REQ_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 9) == 0) ? $urandom : now_us);
                end
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    task automatic add_row(input logic [REQ_W-1:0] kind, input logic level,
                           input logic [TIME_IN_W-1:0] stamp, input check_mode_t mode,
                           input reading_t given);
        directed_q.push_back('{kind, level, stamp, mode, given});
    endtask

    initial
    begin : stimulus
        int i;
        int one_min_set[6];
        int timeout_set[6];
        vector_t v;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_TICK;
        req_ch.line_level <= 1'b0;
        req_ch.time_us <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cur_mode <= CHK_NONE;
        cur_given <= '0;
        idle_on = 1'b0;
        hold_count = 0;
        items_sent = 0;
        readings_predicted = 0;
        errors = 0;
        cycle_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_read_check(REG_BIT_ONE_MIN);
        cfg_read_check(REG_FRAME_TIMEOUT);

        // Idle edge, idle tick and unused code after reset, then timeouts at the exact limit,
        // ignored levels, a restart across the timestamp wrap and the one-bit threshold.
        add_row(REQ_EDGE,   1'b0, 32'd100,         CHK_NONE,    '0);
        add_row(REQ_TICK,   1'b0, 32'hFFFF_FFFF,   CHK_NONE,    '0);
        add_row(REQ_UNUSED, 1'b1, 32'd0,           CHK_NONE,    '0);
        add_row(REQ_ARM,    1'b0, 32'd1000,        CHK_PREDICT, '0);
        add_row(REQ_TICK,   1'b0, 32'd10999,       CHK_NONE,    '0);
        add_row(REQ_TICK,   1'b0, 32'd11000,       CHK_GIVEN,   TIMEOUT_READING);
        add_row(REQ_TICK,   1'b1, 32'd11001,       CHK_NONE,    '0);
        add_row(REQ_ARM,    1'b1, 32'hFFFF_FF00,   CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b1, 32'hFFFF_FF10,   CHK_NONE,    '0);
        add_row(REQ_EDGE,   1'b0, 32'hFFFF_FF20,   CHK_NONE,    '0);
        add_row(REQ_EDGE,   1'b0, 32'hFFFF_FF30,   CHK_NONE,    '0);
        add_row(REQ_ARM,    1'b0, 32'hFFFF_FFFF,   CHK_PREDICT, '0);
        add_row(REQ_TICK,   1'b0, 32'h0000_270E,   CHK_NONE,    '0);
        add_row(REQ_UNUSED, 1'b0, 32'h0000_9000,   CHK_NONE,    '0);
        add_row(REQ_EDGE,   1'b1, 32'h0000_270F,   CHK_GIVEN,   TIMEOUT_READING);
        add_row(REQ_ARM,    1'b0, 32'd0,           CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b0, 32'd5,           CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b1, 32'd85,          CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b0, 32'd165,         CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b1, 32'd215,         CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b0, 32'd260,         CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b1, 32'd300,         CHK_PREDICT, '0);
        add_row(REQ_EDGE,   1'b0, 32'd346,         CHK_PREDICT, '0);
        add_row(REQ_TICK,   1'b1, 32'd9999,        CHK_NONE,    '0);
        add_row(REQ_EDGE,   1'b0, 32'd10000,       CHK_GIVEN,   TIMEOUT_READING);
        for (i = 0; i < directed_q.size(); i++) begin
            v = directed_q[i];
            send(v.kind, v.level, v.stamp, v.mode, v.given);
        end

        // Complete frames: all zero, largest values, negative, negative zero, bad checksum.
        idle_on = 1'b1;
        now_us = 32'h0000_1000;
        send_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, FRAME_BITS, 1'b0);
        send_frame({8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h7C}, FRAME_BITS, 1'b0);
        send_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC}, FRAME_BITS, 1'b0);
        send_frame({8'd40, 8'd5, 8'h80, 8'h00, 8'd173}, FRAME_BITS, 1'b0);
        send_frame({8'd55, 8'd0, 8'd23, 8'd4, 8'd0}, FRAME_BITS, 1'b0);
        drain();

        one_min_set = '{0, 255, 128, 45, 200, 45};
        timeout_set = '{65535, 65535, 1, 6000, 20000, 10000};
        for (i = 0; i < 6; i++) begin
            cfg_write(REG_BIT_ONE_MIN, one_min_set[i]);
            cfg_write(REG_FRAME_TIMEOUT, timeout_set[i]);
            random_phase(PHASE_ITEMS, PHASE_READINGS);
            drain();
        end

        // The receiver holds off while back-to-back timed-out frames keep arriving.
        idle_on = 1'b0;
        hold_count <= hold_count + 1;
        repeat (PRESSURE_PAIRS) begin
            put(REQ_ARM, 1'b0, now_us);
            now_us += timeout_limit;
            put(REQ_TICK, 1'b0, now_us);
        end
        drain();

        if (errors == 0 && readings_due.size() == 0)
            $display("single_wire_sensor_frame_decoder_core: match");
        else
            $display("single_wire_sensor_frame_decoder_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/swsfd_pkg.sv
hw/rtl/swsfd_if.sv
hw/rtl/swsfd_cfg_regs.sv
hw/rtl/swsfd_frame_fsm.sv
hw/rtl/swsfd_reading_calc.sv
hw/rtl/single_wire_sensor_frame_decoder_core.sv
bench/single_wire_sensor_frame_decoder_core_tb.sv
